/* src/rth_pkg.sv */
// types, constants and the divider step shared by the rgb to hsv pixel pipeline
package rth_pkg;

    localparam int CH_W   = 8;
    localparam int QUOT_W = 13;
    localparam int NUM_W  = CH_W + QUOT_W;
    localparam int HUE_W  = 16;
    localparam int SAT_W  = 14;
    localparam int VAL_W  = 13;
    localparam int HQ_W   = 12;

    localparam logic [NUM_W-1:0] SAT_SCALE   = NUM_W'(6400);
    localparam logic [NUM_W-1:0] SECTOR_SPAN = NUM_W'(3840);
    localparam logic [VAL_W-1:0] VALUE_SCALE = VAL_W'(25);
    localparam logic [HUE_W-1:0] GREEN_BASE  = HUE_W'(7680);
    localparam logic [HUE_W-1:0] BLUE_BASE   = HUE_W'(15360);
    localparam logic [HUE_W-1:0] FULL_CIRCLE = HUE_W'(23040);
    localparam logic [HUE_W-1:0] HUE_UNDEF   = 16'hFFC0;
    localparam logic [SAT_W-1:0] SAT_BLACK   = 14'h3FC0;

    typedef enum logic [1:0] {
        SEC_RED   = 2'b00,
        SEC_GREEN = 2'b01,
        SEC_BLUE  = 2'b10
    } sector_t;

    typedef struct packed {
        logic [CH_W-1:0] mx;
        logic [CH_W-1:0] span;
        logic            black;
        logic            grey;
        sector_t         sector;
        logic            neg;
    } side_t;

    typedef struct packed {
        logic [CH_W-1:0]   rem;
        logic [QUOT_W-1:0] lo;
    } div_lane_t;

    // one restoring division step, quotient bit shifts in at the bottom
    function automatic div_lane_t div_step(div_lane_t w, logic [CH_W-1:0] d);
        div_lane_t   r;
        logic [CH_W:0] cand;
        logic [CH_W:0] diff;
        cand = {w.rem, w.lo[QUOT_W-1]};
        diff = cand - {1'b0, d};
        if (cand >= {1'b0, d})
        begin
            r.rem = diff[CH_W-1:0];
            r.lo  = {w.lo[QUOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = cand[CH_W-1:0];
            r.lo  = {w.lo[QUOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

/* src/rth_front.sv */
// input capture, max and min search, sector choice and constant products
module rth_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [rth_pkg::CH_W-1:0]    red_in,
    input  logic [rth_pkg::CH_W-1:0]    green_in,
    input  logic [rth_pkg::CH_W-1:0]    blue_in,
    output logic                        out_valid,
    output rth_pkg::side_t              out_side,
    output logic [rth_pkg::NUM_W-1:0]   sat_num,
    output logic [rth_pkg::NUM_W-1:0]   hue_num
);

    logic                       a_valid_reg;
    logic [rth_pkg::CH_W-1:0]   r_reg;
    logic [rth_pkg::CH_W-1:0]   g_reg;
    logic [rth_pkg::CH_W-1:0]   b_reg;

    logic                       b_valid_reg;
    rth_pkg::side_t             b_side_reg;
    rth_pkg::side_t             b_side_next;
    logic [rth_pkg::CH_W-1:0]   mag_reg;
    logic [rth_pkg::CH_W-1:0]   mag_next;

    logic                       c_valid_reg;
    rth_pkg::side_t             c_side_reg;
    logic [rth_pkg::NUM_W-1:0]  sat_num_reg;
    logic [rth_pkg::NUM_W-1:0]  hue_num_reg;

    logic [rth_pkg::CH_W-1:0]   mx;
    logic [rth_pkg::CH_W-1:0]   mn;
    logic [rth_pkg::CH_W:0]     diff;

    always_comb
    begin
        mx = r_reg;
        if (g_reg > mx)
        begin
            mx = g_reg;
        end
        if (b_reg > mx)
        begin
            mx = b_reg;
        end
        mn = r_reg;
        if (g_reg < mn)
        begin
            mn = g_reg;
        end
        if (b_reg < mn)
        begin
            mn = b_reg;
        end

        b_side_next.mx    = mx;
        b_side_next.span  = mx - mn;
        b_side_next.black = (mx == '0);
        b_side_next.grey  = (mx == mn);

        if (mx == r_reg)
        begin
            b_side_next.sector = rth_pkg::SEC_RED;
            diff = {1'b0, g_reg} - {1'b0, b_reg};
        end
        else if (mx == g_reg)
        begin
            b_side_next.sector = rth_pkg::SEC_GREEN;
            diff = {1'b0, b_reg} - {1'b0, r_reg};
        end
        else
        begin
            b_side_next.sector = rth_pkg::SEC_BLUE;
            diff = {1'b0, r_reg} - {1'b0, g_reg};
        end
        b_side_next.neg = diff[rth_pkg::CH_W];
        if (diff[rth_pkg::CH_W])
        begin
            mag_next = rth_pkg::CH_W'(-diff);
        end
        else
        begin
            mag_next = diff[rth_pkg::CH_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg       <= red_in;
            g_reg       <= green_in;
            b_reg       <= blue_in;
            b_side_reg  <= b_side_next;
            mag_reg     <= mag_next;
            c_side_reg  <= b_side_reg;
            sat_num_reg <= rth_pkg::NUM_W'(b_side_reg.span) * rth_pkg::SAT_SCALE;
            hue_num_reg <= rth_pkg::NUM_W'(mag_reg) * rth_pkg::SECTOR_SPAN;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_side  = c_side_reg;
    assign sat_num   = sat_num_reg;
    assign hue_num   = hue_num_reg;

endmodule

/* src/rth_div_pipe.sv */
// two pipelined restoring dividers, one quotient bit per stage, with sideband
module rth_div_pipe
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  rth_pkg::side_t              in_side,
    input  logic [rth_pkg::NUM_W-1:0]   sat_num,
    input  logic [rth_pkg::NUM_W-1:0]   hue_num,
    output logic                        out_valid,
    output rth_pkg::side_t              out_side,
    output logic [rth_pkg::QUOT_W-1:0]  sat_q,
    output logic [rth_pkg::QUOT_W-1:0]  hue_q
);

    localparam int NST = rth_pkg::QUOT_W;

    logic               valid_w [NST+1];
    rth_pkg::side_t     side_w  [NST+1];
    rth_pkg::div_lane_t sat_w   [NST+1];
    rth_pkg::div_lane_t hue_w   [NST+1];

    assign valid_w[0]   = in_valid;
    assign side_w[0]    = in_side;
    assign sat_w[0].rem = sat_num[rth_pkg::NUM_W-1:rth_pkg::QUOT_W];
    assign sat_w[0].lo  = sat_num[rth_pkg::QUOT_W-1:0];
    assign hue_w[0].rem = hue_num[rth_pkg::NUM_W-1:rth_pkg::QUOT_W];
    assign hue_w[0].lo  = hue_num[rth_pkg::QUOT_W-1:0];

    for (genvar i = 0; i < NST; i++)
    begin : g_stage
        logic               valid_reg;
        rth_pkg::side_t     side_reg;
        rth_pkg::div_lane_t sat_reg;
        rth_pkg::div_lane_t hue_reg;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= 1'b0;
            end
            else if (en)
            begin
                valid_reg <= valid_w[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg <= side_w[i];
                sat_reg  <= rth_pkg::div_step(sat_w[i], side_w[i].mx);
                hue_reg  <= rth_pkg::div_step(hue_w[i], side_w[i].span);
            end
        end

        assign valid_w[i+1] = valid_reg;
        assign side_w[i+1]  = side_reg;
        assign sat_w[i+1]   = sat_reg;
        assign hue_w[i+1]   = hue_reg;
    end

    assign out_valid = valid_w[NST];
    assign out_side  = side_w[NST];
    assign sat_q     = sat_w[NST].lo;
    assign hue_q     = hue_w[NST].lo;

endmodule

/* src/rth_back.sv */
// sector offset, special cases, value scaling and the output register
module rth_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  rth_pkg::side_t              in_side,
    input  logic [rth_pkg::QUOT_W-1:0]  sat_q,
    input  logic [rth_pkg::QUOT_W-1:0]  hue_q,
    output logic                        out_valid,
    output logic [rth_pkg::HUE_W-1:0]   hue_out,
    output logic [rth_pkg::SAT_W-1:0]   saturation_out,
    output logic [rth_pkg::VAL_W-1:0]   value_out
);

    logic                        valid_reg;
    logic [rth_pkg::HUE_W-1:0]   hue_reg;
    logic [rth_pkg::HUE_W-1:0]   hue_next;
    logic [rth_pkg::SAT_W-1:0]   sat_reg;
    logic [rth_pkg::SAT_W-1:0]   sat_next;
    logic [rth_pkg::VAL_W-1:0]   val_reg;
    logic [rth_pkg::HUE_W-1:0]   q;
    logic [rth_pkg::HUE_W-1:0]   base;

    always_comb
    begin
        q = rth_pkg::HUE_W'(hue_q[rth_pkg::HQ_W-1:0]);
        case (in_side.sector)
            rth_pkg::SEC_GREEN: base = rth_pkg::GREEN_BASE;
            rth_pkg::SEC_BLUE:  base = rth_pkg::BLUE_BASE;
            default:            base = '0;
        endcase

        if (in_side.black || in_side.grey)
        begin
            hue_next = rth_pkg::HUE_UNDEF;
        end
        else if (!in_side.neg)
        begin
            hue_next = base + q;
        end
        else if (in_side.sector == rth_pkg::SEC_RED)
        begin
            // negative red hue wraps round the circle
            hue_next = (q == '0) ? '0 : rth_pkg::FULL_CIRCLE - q;
        end
        else
        begin
            hue_next = base - q;
        end

        if (in_side.black)
        begin
            sat_next = rth_pkg::SAT_BLACK;
        end
        else
        begin
            sat_next = rth_pkg::SAT_W'(sat_q);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            val_reg <= rth_pkg::VAL_W'(in_side.mx) * rth_pkg::VALUE_SCALE;
        end
    end

    assign out_valid      = valid_reg;
    assign hue_out        = hue_reg;
    assign saturation_out = sat_reg;
    assign value_out      = val_reg;

endmodule

/* src/rgb_to_hsv_pixel.sv */
// top level of the rgb to hsv pixel converter
//
//  channel   signals                       request contents
//  pixel in  s_tvalid s_tready s_tdata     red, green, blue, 8 bits each
//  hsv out   m_tvalid m_tready m_tdata     hue 16, saturation 14, value 13
//
// one pixel per cycle while the output request is not held waiting
// a pixel passes 3 front stages, the 13-stage restoring dividers and the output register
// rst_n clears all valid bits, data registers are not reset
// the whole pipeline holds while the output request waits, nothing is lost
module rgb_to_hsv_pixel
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // red_in [7:0], green_in [15:8], blue_in [23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata   // hue_out [15:0], saturation_out [29:16], value_out [42:30]
);

    logic                         en;
    logic                         f_valid;
    rth_pkg::side_t               f_side;
    logic [rth_pkg::NUM_W-1:0]    f_sat_num;
    logic [rth_pkg::NUM_W-1:0]    f_hue_num;
    logic                         d_valid;
    rth_pkg::side_t               d_side;
    logic [rth_pkg::QUOT_W-1:0]   d_sat_q;
    logic [rth_pkg::QUOT_W-1:0]   d_hue_q;
    logic [rth_pkg::HUE_W-1:0]    hue_out;
    logic [rth_pkg::SAT_W-1:0]    saturation_out;
    logic [rth_pkg::VAL_W-1:0]    value_out;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    rth_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .red_in    (s_tdata[7:0]),
        .green_in  (s_tdata[15:8]),
        .blue_in   (s_tdata[23:16]),
        .out_valid (f_valid),
        .out_side  (f_side),
        .sat_num   (f_sat_num),
        .hue_num   (f_hue_num)
    );

    rth_div_pipe u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .in_side   (f_side),
        .sat_num   (f_sat_num),
        .hue_num   (f_hue_num),
        .out_valid (d_valid),
        .out_side  (d_side),
        .sat_q     (d_sat_q),
        .hue_q     (d_hue_q)
    );

    rth_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .in_valid       (d_valid),
        .in_side        (d_side),
        .sat_q          (d_sat_q),
        .hue_q          (d_hue_q),
        .out_valid      (m_tvalid),
        .hue_out        (hue_out),
        .saturation_out (saturation_out),
        .value_out      (value_out)
    );

    assign m_tdata = {5'b0, value_out, saturation_out, hue_out};

endmodule

/* tb/rgb_to_hsv_pixel_tb.sv */
`timescale 1ns / 100ps
// self-checking testbench for the rgb to hsv pixel converter, directed and random pixels
module rgb_to_hsv_pixel_tb;

    typedef struct {
        logic signed [rth_pkg::HUE_W-1:0] hue;
        logic signed [rth_pkg::SAT_W-1:0] sat;
        logic [rth_pkg::VAL_W-1:0]        val;
    } hsv_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;  // red_in [7:0], green_in [15:8], blue_in [23:16]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // hue_out [15:0], saturation_out [29:16], value_out [42:30]

    int   feed_gap_pct    = 0;
    int   drain_stall_pct = 0;
    int   mismatches      = 0;
    hsv_t pending_hsv[$];

    rgb_to_hsv_pixel uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic hsv_t predict_hsv(logic [rth_pkg::CH_W-1:0] r,
                                         logic [rth_pkg::CH_W-1:0] g,
                                         logic [rth_pkg::CH_W-1:0] b);
        hsv_t             p;
        rth_pkg::sector_t sec;
        int               ri;
        int               gi;
        int               bi;
        int               mx;
        int               mn;
        int               span;
        int               h;
        ri = int'(r);
        gi = int'(g);
        bi = int'(b);
        mx = ri;
        if (gi > mx) mx = gi;
        if (bi > mx) mx = bi;
        mn = ri;
        if (gi < mn) mn = gi;
        if (bi < mn) mn = bi;
        span  = mx - mn;
        p.val = rth_pkg::VAL_W'(mx * int'(rth_pkg::VALUE_SCALE));
        if (mx == 0)
        begin
            p.hue = rth_pkg::HUE_UNDEF;
            p.sat = rth_pkg::SAT_BLACK;
        end
        else
        begin
            p.sat = rth_pkg::SAT_W'(span * int'(rth_pkg::SAT_SCALE) / mx);
            if (span == 0)
                p.hue = rth_pkg::HUE_UNDEF;
            else
            begin
                // ties go to red, then green
                if (mx == ri)
                    sec = rth_pkg::SEC_RED;
                else if (mx == gi)
                    sec = rth_pkg::SEC_GREEN;
                else
                    sec = rth_pkg::SEC_BLUE;
                case (sec)
                    rth_pkg::SEC_RED:
                    begin
                        h = int'(rth_pkg::SECTOR_SPAN) * (gi - bi) / span;
                        if (h < 0) h = h + int'(rth_pkg::FULL_CIRCLE);
                    end
                    rth_pkg::SEC_GREEN:
                        h = int'(rth_pkg::GREEN_BASE)
                            + int'(rth_pkg::SECTOR_SPAN) * (bi - ri) / span;
                    default:
                        h = int'(rth_pkg::BLUE_BASE)
                            + int'(rth_pkg::SECTOR_SPAN) * (ri - gi) / span;
                endcase
                p.hue = rth_pkg::HUE_W'(h);
            end
        end
        return p;
    endfunction

    task automatic send_pixel(input logic [rth_pkg::CH_W-1:0] r,
                              input logic [rth_pkg::CH_W-1:0] g,
                              input logic [rth_pkg::CH_W-1:0] b);
        while ($urandom_range(99) < feed_gap_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 24'($urandom);
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pending_hsv.push_back(predict_hsv(r, g, b));
    endtask

    task automatic test_black_and_grey();
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd1, 8'd1, 8'd1);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd255, 8'd255);
    endtask

    task automatic test_sector_extremes();
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd0, 8'd1);
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd10, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd1, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd1, 8'd2);
        send_pixel(8'd1, 8'd0, 8'd2);
    endtask

    task automatic test_dominant_ties();
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd200, 8'd200, 8'd100);
    endtask

    task automatic test_truncation_and_bits();
        // negative hue terms that do not divide evenly, then mixed bit patterns
        send_pixel(8'd7, 8'd0, 8'd1);
        send_pixel(8'd3, 8'd7, 8'd0);
        send_pixel(8'd0, 8'd5, 8'd7);
        send_pixel(8'hAA, 8'h55, 8'h0F);
        send_pixel(8'h55, 8'hAA, 8'hF0);
    endtask

    task automatic test_random_pixels(input int count);
        logic [rth_pkg::CH_W-1:0] r;
        logic [rth_pkg::CH_W-1:0] g;
        logic [rth_pkg::CH_W-1:0] b;
        for (int i = 0; i < count; i++)
        begin
            r = rth_pkg::CH_W'($urandom);
            g = rth_pkg::CH_W'($urandom);
            b = rth_pkg::CH_W'($urandom);
            case ($urandom_range(9))
                0:
                begin
                    g = r;
                    b = r;
                end
                1: g = r;
                2: b = g;
                3: b = r;
                4:
                begin
                    r = rth_pkg::CH_W'($urandom_range(7));
                    g = rth_pkg::CH_W'($urandom_range(7));
                    b = rth_pkg::CH_W'($urandom_range(7));
                end
                default: ;
            endcase
            send_pixel(r, g, b);
        end
    endtask

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= drain_stall_pct);

    always @(posedge clk)
    begin : check_hsv
        hsv_t want;
        hsv_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.hue = m_tdata[15:0];
            got.sat = m_tdata[29:16];
            got.val = m_tdata[42:30];
            if (pending_hsv.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected request, expected none, actual hue %0d sat %0d value %0d",
                         $time, got.hue, got.sat, got.val);
            end
            else
            begin
                want = pending_hsv.pop_front();
                if (got.hue !== want.hue)
                begin
                    mismatches++;
                    $display("%0t: hue_out expected %0d actual %0d", $time, want.hue, got.hue);
                end
                if (got.sat !== want.sat)
                begin
                    mismatches++;
                    $display("%0t: saturation_out expected %0d actual %0d", $time, want.sat,
                             got.sat);
                end
                if (got.val !== want.val)
                begin
                    mismatches++;
                    $display("%0t: value_out expected %0d actual %0d", $time, want.val, got.val);
                end
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        feed_gap_pct    = 22;
        drain_stall_pct = 77;
        test_black_and_grey();
        test_sector_extremes();
        test_dominant_ties();
        test_truncation_and_bits();
        test_random_pixels(440);
        feed_gap_pct    = 77;
        drain_stall_pct = 22;
        test_random_pixels(440);
        feed_gap_pct    = 0;
        drain_stall_pct = 0;
        test_random_pixels(445);
        s_tvalid <= 1'b0;
        while (pending_hsv.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule

/* rgb_to_hsv_pixel.f */
src/rth_pkg.sv
src/rth_front.sv
src/rth_div_pipe.sv
src/rth_back.sv
src/rgb_to_hsv_pixel.sv
tb/rgb_to_hsv_pixel_tb.sv
